FILE: rtl/assert_macros.svh
// Assertion helpers shared by the checker modules.
// Both macros expect signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define MSEL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a rising clock edge outside of reset.
`define MSEL_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/msel_pkg.sv
`default_nettype none

package msel_pkg;

	// Sizing
	localparam int PALETTE_DEPTH  = 64;
	localparam int MAX_RUN_PIXELS = 1048576;

	localparam int IDX_W   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int SIZE_W  = $clog2(PALETTE_DEPTH + 1);
	localparam int COUNT_W = $clog2(MAX_RUN_PIXELS + 2);
	localparam int SUM_W   = $clog2(longint'(MAX_RUN_PIXELS) * 255 + 1);
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int TILE_W  = 6;
	localparam int DIST_W  = 18;

	// Divider: one quotient bit per channel per cycle
	localparam int QUOT_STEPS = CHAN_W;
	localparam int STEP_W     = $clog2(QUOT_STEPS);
	localparam int DIV_W      = (SUM_W > COUNT_W + QUOT_STEPS - 1) ? SUM_W
	                                                              : COUNT_W + QUOT_STEPS - 1;

	// Channel slots in packed per-channel arrays
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef enum logic [1:0] {
		KIND_REF    = 2'd0,
		KIND_TARGET = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STATUS_MATCH    = 3'd0,
		STATUS_STORED   = 3'd1,
		STATUS_EMPTY    = 3'd2,
		STATUS_FULL     = 3'd3,
		STATUS_CLEARED  = 3'd4,
		STATUS_TOO_LONG = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_ACCUM,
		S_DIVIDE,
		S_SEARCH
	} state_t;

	// Search token moving down the cell chain
	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [DIST_W-1:0] sqd;
		logic [IDX_W-1:0]  idx;
	} query_t;

	// Palette write broadcast to every cell
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [COLOR_W-1:0] color;
	} pal_wr_t;

endpackage

`default_nettype wire

FILE: rtl/mosaic_tile_selector_core.sv
`default_nettype none

// Mosaic tile selector. Pixels are taken one per cycle and summed per channel
// until the pixel marked last. A finished run then goes through the shared
// three-channel divider for its mean. A reference run stores the mean in the
// next palette cell and its result (stored, full or empty palette for a
// target run) is registered when the divider is done. A target run with a
// non-empty palette sends its mean down the chain of 64 palette cells, one
// cell per cycle, and its match is registered when the token leaves the last
// cell. Clear and overlong-run results follow in the next cycle.
// Input stalls while a run is being finished and while a result waits to be
// taken on the output.
module mosaic_tile_selector_core import msel_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [TILE_W-1:0] tile_index,
	output logic [CHAN_W-1:0] mean_red,
	output logic [CHAN_W-1:0] mean_green,
	output logic [CHAN_W-1:0] mean_blue
);

	state_t                 state_q;
	state_t                 state_nx;
	logic [2:0][SUM_W-1:0]  sum_q;
	logic [2:0][SUM_W-1:0]  sum_nx;
	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     count_nx;
	logic [SIZE_W-1:0]      pal_size_q;
	kind_t                  run_kind_q;
	kind_t                  in_kind;

	logic                   in_take;
	logic                   is_pixel;
	logic                   is_clear;
	logic                   room;
	logic                   run_end;
	logic                   div_start;
	logic                   div_done;
	logic [2:0][CHAN_W-1:0] quot;
	logic                   pal_full;
	logic                   search_done;

	pal_wr_t                pal_wr;
	query_t                 launch;
	query_t                 chain [PALETTE_DEPTH+1];

	logic                   res_load;
	status_t                res_status;
	logic [IDX_W-1:0]       res_idx;
	logic                   res_zero;

	logic                   out_valid_q;
	status_t                status_q;
	logic [TILE_W-1:0]      tile_index_q;
	logic [2:0][CHAN_W-1:0] mean_q;

	// Input transaction decode
	assign in_stall = (state_q != S_ACCUM) || out_valid_q;
	assign in_take  = in_valid && !in_stall;
	assign in_kind  = kind_t'(kind);
	assign is_pixel = in_take && ((in_kind == KIND_REF) || (in_kind == KIND_TARGET));
	assign is_clear = in_take && (in_kind == KIND_CLEAR);

	// Accumulation; pixels past the run limit only saturate the count
	always_comb begin
		room = count_q < COUNT_W'(MAX_RUN_PIXELS);
		sum_nx[CH_RED]   = sum_q[CH_RED]   + SUM_W'(red);
		sum_nx[CH_GREEN] = sum_q[CH_GREEN] + SUM_W'(green);
		sum_nx[CH_BLUE]  = sum_q[CH_BLUE]  + SUM_W'(blue);
		count_nx         = count_q + 1'b1;
		if (!room) begin
			sum_nx   = sum_q;
			count_nx = COUNT_W'(MAX_RUN_PIXELS + 1);
		end
	end

	assign run_end   = is_pixel && last;
	assign div_start = run_end && room;

	assign pal_full    = pal_size_q >= SIZE_W'(PALETTE_DEPTH);
	assign search_done = chain[PALETTE_DEPTH].valid;

	msel_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sums   (sum_nx),
		.count  (count_nx),
		.done   (div_done),
		.quot   (quot)
	);

	// Palette cell chain
	assign chain[0] = launch;

	for (genvar gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_cell
		msel_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(gi)),
			.pal_size (pal_size_q),
			.pal_wr   (pal_wr),
			.q_in     (chain[gi]),
			.q_out    (chain[gi+1])
		);
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_ACCUM: begin
				if (div_start) state_nx = S_DIVIDE;
			end
			S_DIVIDE: begin
				if (div_done) begin
					if ((run_kind_q == KIND_TARGET) && (pal_size_q != '0)) begin
						state_nx = S_SEARCH;
					end else begin
						state_nx = S_ACCUM;
					end
				end
			end
			S_SEARCH: begin
				if (search_done) state_nx = S_ACCUM;
			end
			default: state_nx = S_ACCUM;
		endcase
	end

	// State outputs: result load, palette write, search launch
	always_comb begin
		res_load     = 1'b0;
		res_status   = STATUS_MATCH;
		res_idx      = '0;
		res_zero     = 1'b0;
		pal_wr       = '0;
		launch       = '0;
		unique case (state_q)
			S_ACCUM: begin
				if (is_clear) begin
					res_load   = 1'b1;
					res_status = STATUS_CLEARED;
					res_zero   = 1'b1;
				end else if (run_end && !room) begin
					res_load   = 1'b1;
					res_status = STATUS_TOO_LONG;
					res_zero   = 1'b1;
				end
			end
			S_DIVIDE: begin
				if (div_done) begin
					if (run_kind_q != KIND_TARGET) begin
						res_load = 1'b1;
						if (pal_full) begin
							res_status = STATUS_FULL;
						end else begin
							res_status   = STATUS_STORED;
							pal_wr.en    = 1'b1;
							pal_wr.addr  = IDX_W'(pal_size_q);
							pal_wr.color = {quot[CH_RED], quot[CH_GREEN], quot[CH_BLUE]};
						end
					end else if (pal_size_q == '0) begin
						res_load   = 1'b1;
						res_status = STATUS_EMPTY;
					end else begin
						launch.valid = 1'b1;
						launch.red   = quot[CH_RED];
						launch.green = quot[CH_GREEN];
						launch.blue  = quot[CH_BLUE];
						launch.sqd   = '1;
						launch.idx   = '0;
					end
				end
			end
			S_SEARCH: begin
				if (search_done) begin
					res_load   = 1'b1;
					res_status = STATUS_MATCH;
					res_idx    = chain[PALETTE_DEPTH].idx;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Control state and run accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_ACCUM;
			sum_q      <= '0;
			count_q    <= '0;
			pal_size_q <= '0;
			run_kind_q <= KIND_REF;
		end else begin
			state_q <= state_nx;
			if (is_clear) begin
				sum_q      <= '0;
				count_q    <= '0;
				pal_size_q <= '0;
			end else if (is_pixel) begin
				if (last) begin
					sum_q      <= '0;
					count_q    <= '0;
					run_kind_q <= in_kind;
				end else begin
					sum_q   <= sum_nx;
					count_q <= count_nx;
				end
			end
			if (pal_wr.en) begin
				pal_size_q <= pal_size_q + 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q     <= res_status;
			tile_index_q <= TILE_W'(res_idx);
			mean_q       <= res_zero ? '0 : quot;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign tile_index = tile_index_q;
	assign mean_red   = mean_q[CH_RED];
	assign mean_green = mean_q[CH_GREEN];
	assign mean_blue  = mean_q[CH_BLUE];

endmodule

`default_nettype wire

FILE: rtl/msel_divider.sv
`default_nettype none

// Restoring divider for the three channel sums by the pixel count.
// The mean never exceeds the channel maximum, so CHAN_W quotient bits suffice.
module msel_divider import msel_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [2:0][SUM_W-1:0]        sums,
	input  logic [COUNT_W-1:0]           count,
	output logic                         done,
	output logic [2:0][CHAN_W-1:0]       quot
);

	logic [2:0][DIV_W-1:0]  rem_q;
	logic [2:0][DIV_W-1:0]  rem_nx;
	logic [2:0][CHAN_W-1:0] quot_q;
	logic [2:0]             ge;
	logic [DIV_W-1:0]       dsh_q;
	logic [STEP_W-1:0]      step_q;
	logic                   busy_q;
	logic                   done_q;

	// One trial subtraction per channel
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ge[c]     = rem_q[c] >= dsh_q;
			rem_nx[c] = ge[c] ? (rem_q[c] - dsh_q) : rem_q[c];
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUOT_STEPS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainders, shifted divisor, quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= DIV_W'(sums[c]);
			end
			dsh_q  <= DIV_W'(count) << (QUOT_STEPS - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c]  <= rem_nx[c];
				quot_q[c] <= {quot_q[c][CHAN_W-2:0], ge[c]};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

FILE: rtl/msel_cell.sv
`default_nettype none

// One palette entry. Compares the passing search token against its color
// and hands the token, with the better candidate, to the next cell.
module msel_cell import msel_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  cell_idx,
	input  logic [SIZE_W-1:0] pal_size,
	input  pal_wr_t           pal_wr,
	input  query_t            q_in,
	output query_t            q_out
);

	logic [COLOR_W-1:0] color_q;
	logic [CHAN_W-1:0]  ent_r;
	logic [CHAN_W-1:0]  ent_g;
	logic [CHAN_W-1:0]  ent_b;
	logic [CHAN_W-1:0]  dr;
	logic [CHAN_W-1:0]  dg;
	logic [CHAN_W-1:0]  db;
	logic [DIST_W-1:0]  ent_sqd;
	logic               live;
	query_t             q_nx;
	query_t             q_s1;

	assign ent_r = color_q[COLOR_W-1 -: CHAN_W];
	assign ent_g = color_q[CHAN_W +: CHAN_W];
	assign ent_b = color_q[CHAN_W-1:0];

	// Squared distance to the stored color
	always_comb begin
		dr      = (q_in.red   > ent_r) ? (q_in.red   - ent_r) : (ent_r - q_in.red);
		dg      = (q_in.green > ent_g) ? (q_in.green - ent_g) : (ent_g - q_in.green);
		db      = (q_in.blue  > ent_b) ? (q_in.blue  - ent_b) : (ent_b - q_in.blue);
		ent_sqd = DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dg) * DIST_W'(dg)
		        + DIST_W'(db) * DIST_W'(db);
	end

	// Strictly smaller wins, so the lower index keeps a tie
	always_comb begin
		live = SIZE_W'(cell_idx) < pal_size;
		q_nx = q_in;
		if (live && (ent_sqd < q_in.sqd)) begin
			q_nx.sqd = ent_sqd;
			q_nx.idx = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s1 <= '0;
		end else begin
			q_s1 <= q_nx;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (pal_wr.en && (pal_wr.addr == cell_idx)) begin
			color_q <= pal_wr.color;
		end
	end

	assign q_out = q_s1;

endmodule

`default_nettype wire

FILE: rtl/msel_checker.sv
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the tile selector.
module msel_checker import msel_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [2:0]        status,
	input logic [TILE_W-1:0] tile_index,
	input logic [CHAN_W-1:0] mean_red,
	input logic [CHAN_W-1:0] mean_green,
	input logic [CHAN_W-1:0] mean_blue
);

	// A stalled result transaction holds
	`MSEL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(tile_index), "stalled result changed")

	// Only a match carries a tile index
	`MSEL_ASSERT_NEVER(a_idx_zero, out_valid && (status != STATUS_MATCH) && (tile_index != '0), "tile index without match")

	// Clear and overlong runs report zero means
	`MSEL_ASSERT_NEVER(a_means_zero, out_valid && ((status == STATUS_CLEARED) || (status == STATUS_TOO_LONG)) && ((mean_red != '0) || (mean_green != '0) || (mean_blue != '0)), "nonzero means on clear or overlong run")

	// No input is taken while a result waits
	`MSEL_ASSERT_NEVER(a_in_blocked, out_valid && !in_stall, "input open while result pending")

endmodule

bind mosaic_tile_selector_core msel_checker u_msel_checker (.*);

`default_nettype wire
